### sv/ett_pkg.sv
package ett_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int KEY_BITS_DEF    = 64;

  localparam int KEY_W  = 64;  // token_key field width
  localparam int TIME_W = 31;  // current_time and time_to_live width
  localparam int EXP_W  = 32;  // stored expiry, never wraps
  localparam int REQ_W  = 2;
  localparam int CNT_W  = 5;
  localparam int STS_W  = 2;

  localparam logic [TIME_W-1:0] TTL_RESET = TIME_W'(1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

  localparam logic [REQ_W-1:0] REQ_GEN   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RENEW = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COUNT = 2'd2;

  localparam logic [STS_W-1:0] STS_DONE    = 2'd0;
  localparam logic [STS_W-1:0] STS_IGNORED = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL    = 2'd2;

  // result of the shared compare unit for one table entry
  typedef struct packed {
    logic key_eq;
    logic live;
  } ett_cmp_t;

endpackage

### sv/expiring_token_table_top.sv
// Channel   Direction  Handshake                 Payload
// request   in         in_valid_i / in_stall_o   req_type_i, token_key_i, current_time_i
// result    out        out_valid_o / out_stall_i live_count_o, status_o
// config    in         cfg_we_i                  cfg_wdata_i (time_to_live)
//
// A request makes one pass over the key/expiry RAM through its single read
// port (one entry per cycle, read data registered in the RAM), then goes to the
// update state S_WR and to S_DONE, which loads the output register. in_stall_o
// is high for the whole pass and until the sequencer returns to idle.
// Reset clears the valid bits at once; no clearing pass is needed.
// A stalled result holds the sequencer before it returns to idle.
module expiring_token_table_top
  import ett_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [TIME_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [KEY_W-1:0]  token_key_i,
  input  logic [TIME_W-1:0] current_time_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CNT_W-1:0]  live_count_o,
  output logic [STS_W-1:0]  status_o
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int ENT_W = KEY_BITS + EXP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WR   = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [TIME_W-1:0]      ttl_q;
  logic [REQ_W-1:0]       req_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [TIME_W-1:0]      now_q;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;

  logic             iss_q, iss_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic             ev_vld_q, ev_vld_d;
  logic [IDX_W-1:0] ev_idx_q, ev_idx_d;

  logic             found_q, found_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic             hit_live_q, hit_live_d;
  logic             free_q, free_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [STS_W-1:0] sts_q, sts_d;

  logic             out_valid_q, out_valid_d;
  logic [CNT_W-1:0] out_cnt_q;
  logic [STS_W-1:0] out_sts_q;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [ENT_W-1:0] ram_rdata;
  logic [EXP_W-1:0] expiry;
  ett_cmp_t         cmp;

  logic in_acc, out_free, ent_valid, ent_hit, ent_live;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign expiry     = {1'b0, now_q} + {1'b0, ttl_q};

  ett_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (iss_q),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  ett_cmp #(
    .KEY_BITS (KEY_BITS)
  ) u_cmp (
    .ent_key_i (ram_rdata[ENT_W-1:EXP_W]),
    .ent_exp_i (ram_rdata[EXP_W-1:0]),
    .req_key_i (key_q),
    .now_i     (now_q),
    .res_o     (cmp)
  );

  // key/expiry of entries never written are masked by their valid bit
  assign ent_valid = valid_q[ev_idx_q];
  assign ent_hit   = ent_valid && cmp.key_eq;
  assign ent_live  = ent_valid && cmp.live;

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    iss_d       = iss_q;
    rd_idx_d    = rd_idx_q;
    ev_vld_d    = 1'b0;
    ev_idx_d    = rd_idx_q;
    found_d     = found_q;
    hit_idx_d   = hit_idx_q;
    hit_live_d  = hit_live_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    cnt_d       = cnt_q;
    sts_d       = sts_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_waddr   = hit_idx_q;
    ram_wdata   = {key_q, expiry};

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d  = S_SCAN;
          iss_d    = 1'b1;
          rd_idx_d = '0;
          found_d  = 1'b0;
          free_d   = 1'b0;
          cnt_d    = '0;
        end
      end
      S_SCAN: begin
        // issue side
        ev_vld_d = iss_q;
        if (iss_q) begin
          if (rd_idx_q == LAST_IDX) begin
            iss_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q + 1'b1;
          end
        end
        // evaluate side, on the RAM data read in the cycle before
        if (ev_vld_q) begin
          if (ent_hit && !found_q) begin
            found_d    = 1'b1;
            hit_idx_d  = ev_idx_q;
            hit_live_d = cmp.live;
          end
          if (!ent_live && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = ev_idx_q;
          end
          if (req_q == REQ_COUNT) begin
            if (ent_live) begin
              if (cnt_q != CNT_MAX) begin
                cnt_d = cnt_q + 1'b1;
              end
            end else begin
              valid_d[ev_idx_q] = 1'b0;
            end
          end
          if (ev_idx_q == LAST_IDX) begin
            state_d = S_WR;
          end
        end
      end
      S_WR: begin
        sts_d   = STS_DONE;
        state_d = S_DONE;
        case (req_q)
          REQ_GEN: begin
            if (found_q) begin
              ram_we    = 1'b1;
              ram_waddr = hit_idx_q;
            end else if (free_q) begin
              ram_we    = 1'b1;
              ram_waddr = free_idx_q;
            end else begin
              sts_d = STS_FULL;
            end
            if (ram_we) begin
              valid_d[ram_waddr] = 1'b1;
            end
          end
          REQ_RENEW: begin
            // stored key equals the request key on a hit
            if (found_q && hit_live_q) begin
              ram_we    = 1'b1;
              ram_waddr = hit_idx_q;
            end else begin
              sts_d = STS_IGNORED;
            end
          end
          default: begin
          end
        endcase
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ttl_q       <= TTL_RESET;
      valid_q     <= '0;
      iss_q       <= 1'b0;
      ev_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      iss_q       <= iss_d;
      ev_vld_q    <= ev_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        ttl_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= req_type_i;
      key_q <= token_key_i[KEY_BITS-1:0];
      now_q <= current_time_i;
    end
    rd_idx_q   <= rd_idx_d;
    ev_idx_q   <= ev_idx_d;
    found_q    <= found_d;
    hit_idx_q  <= hit_idx_d;
    hit_live_q <= hit_live_d;
    free_q     <= free_d;
    free_idx_q <= free_idx_d;
    cnt_q      <= cnt_d;
    sts_q      <= sts_d;
    if (state_q == S_DONE && out_free) begin
      out_cnt_q <= cnt_q;
      out_sts_q <= sts_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign live_count_o = out_cnt_q;
  assign status_o     = out_sts_q;

  a_ram_wr_only_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_WR))
    else $error("table written outside update cycle");

  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && req_q == REQ_COUNT) |->
      ((($countones(valid_q) > 31) && (cnt_q == CNT_MAX)) ||
       (32'($countones(valid_q)) == 32'(cnt_q))))
    else $error("live count disagrees with valid bits after count");

  a_hit_is_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR && found_q && req_q != REQ_COUNT) |-> valid_q[hit_idx_q])
    else $error("key hit on an invalid slot");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result raised outside done state");

endmodule

### sv/ett_ram.sv
module ett_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/ett_cmp.sv
module ett_cmp
  import ett_pkg::*;
#(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic [KEY_BITS-1:0] ent_key_i,
  input  logic [EXP_W-1:0]    ent_exp_i,
  input  logic [KEY_BITS-1:0] req_key_i,
  input  logic [TIME_W-1:0]   now_i,
  output ett_cmp_t            res_o
);

  always_comb begin
    res_o.key_eq = (ent_key_i == req_key_i);
    res_o.live   = (ent_exp_i > {1'b0, now_i});
  end

endmodule
